FILE: hdl/mbp_pkg.sv
// Package for the multi-channel byte pipe: sizes, mode and status codes,
// and the structs passed between the channel control and the top level.
// No dependencies.
package mbp_pkg;

   // block sizes
   localparam int NUM_CHANNELS = 8;
   localparam int RING_BYTES   = 256;

   // field widths
   localparam int MODE_W   = 3;
   localparam int CHAN_W   = 4;
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 16;

   // derived widths
   localparam int CH_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int IDX_W   = $clog2(RING_BYTES);
   localparam int DEPTH   = NUM_CHANNELS * RING_BYTES;
   localparam int ADDR_W  = $clog2(DEPTH);

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [MODE_W-1:0] {
      MODE_CREATE    = 3'd0,
      MODE_CLOSE_RD  = 3'd1,
      MODE_CLOSE_WR  = 3'd2,
      MODE_WRITE     = 3'd3,
      MODE_READ      = 3'd4,
      MODE_QUERY     = 3'd5
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 3'd0,
      ST_BAD_CHANNEL = 3'd1,
      ST_NO_FREE     = 3'd2,
      ST_WOULD_BLOCK = 3'd3,
      ST_NO_READER   = 3'd4,
      ST_END_OF_DATA = 3'd5
   } status_type;

   // ring memory request from the channel control
   typedef struct packed {
      logic              we;
      logic              re;
      logic [ADDR_W-1:0] addr;
      logic [BYTE_W-1:0] wdata;
   } mem_req_type;

   // result fields known at the end of the control stage
   typedef struct packed {
      status_type         status;
      logic [CHAN_W-1:0]  channel_out;
      logic               has_data;
      logic [COUNT_W-1:0] bytes_done;
      logic               rd_pending;
   } result_type;

   // next ring slot with wrap
   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] nxt;
      if (idx == IDX_W'(RING_BYTES - 1)) begin
         nxt = '0;
      end else begin
         nxt = idx + IDX_W'(1);
      end
      return nxt;
   endfunction

endpackage

FILE: hdl/mbp_if.sv
// Valid/ready channel interfaces for the byte pipe request and response items.
// Depends on mbp_pkg.
interface mbp_req_if;
   import mbp_pkg::*;

   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [CHAN_W-1:0] channel;
   logic [BYTE_W-1:0] data_in;
   logic              last_byte;

   modport source (output valid, mode, channel, data_in, last_byte, input ready);
   modport sink   (input valid, mode, channel, data_in, last_byte, output ready);
endinterface

interface mbp_rsp_if;
   import mbp_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [BYTE_W-1:0]   data_out;
   logic [CHAN_W-1:0]   channel_out;
   logic                has_data;
   logic [COUNT_W-1:0]  bytes_done;

   modport source (output valid, status, data_out, channel_out, has_data, bytes_done,
                   input ready);
   modport sink   (input valid, status, data_out, channel_out, has_data, bytes_done,
                   output ready);
endinterface

FILE: hdl/mbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

FILE: hdl/mbp_ctrl.sv
// Channel table and per-item decision logic for the byte pipe: open flags,
// ring indices, transfer count, ring memory requests. Depends on mbp_pkg.
module mbp_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      fire,
   input  logic [mbp_pkg::MODE_W-1:0] mode,
   input  logic [mbp_pkg::CHAN_W-1:0] channel,
   input  logic [mbp_pkg::BYTE_W-1:0] data_in,
   input  logic                      last_byte,
   output mbp_pkg::mem_req_type      mem_req,
   output mbp_pkg::result_type       result
);
   import mbp_pkg::*;

   logic [NUM_CHANNELS-1:0] in_use_ff, in_use_in;
   logic [NUM_CHANNELS-1:0] rd_open_ff, rd_open_in;
   logic [NUM_CHANNELS-1:0] wr_open_ff, wr_open_in;
   logic [IDX_W-1:0]        wr_idx_ff [NUM_CHANNELS];
   logic [IDX_W-1:0]        wr_idx_in [NUM_CHANNELS];
   logic [IDX_W-1:0]        rd_idx_ff [NUM_CHANNELS];
   logic [IDX_W-1:0]        rd_idx_in [NUM_CHANNELS];
   logic [COUNT_W-1:0]      count_ff, count_in, count_mid;

   logic                    ch_ok, out_ok, free_found, moved, clear;
   logic [CH_W-1:0]         ch, free_idx, out_idx;
   logic [IDX_W-1:0]        cur_wr, cur_rd;
   logic [CHAN_W-1:0]       ch_out;
   status_type              status;

   assign ch_ok = {1'b0, channel} < (CHAN_W + 1)'(NUM_CHANNELS);
   assign ch    = channel[CH_W-1:0];

   // lowest unused channel
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (!in_use_ff[i]) begin
            free_found = 1'b1;
            free_idx   = CH_W'(i);
         end
      end
   end

   // per-item decision and next table state
   always_comb begin
      in_use_in  = in_use_ff;
      rd_open_in = rd_open_ff;
      wr_open_in = wr_open_ff;
      wr_idx_in  = wr_idx_ff;
      rd_idx_in  = rd_idx_ff;
      status     = ST_OK;
      ch_out     = channel;
      moved      = 1'b0;
      mem_req    = '0;
      cur_wr     = ch_ok ? wr_idx_ff[ch] : '0;
      cur_rd     = ch_ok ? rd_idx_ff[ch] : '0;
      case (mode)
         MODE_CREATE: begin
            if (free_found) begin
               in_use_in[free_idx]  = 1'b1;
               rd_open_in[free_idx] = 1'b1;
               wr_open_in[free_idx] = 1'b1;
               wr_idx_in[free_idx]  = '0;
               rd_idx_in[free_idx]  = '0;
               ch_out               = CHAN_W'(free_idx);
            end else begin
               status = ST_NO_FREE;
            end
         end
         MODE_CLOSE_RD: begin
            if (!ch_ok) begin
               status = ST_BAD_CHANNEL;
            end else begin
               rd_open_in[ch] = 1'b0;
               if (!wr_open_ff[ch]) begin
                  in_use_in[ch] = 1'b0;
               end
            end
         end
         MODE_CLOSE_WR: begin
            if (!ch_ok) begin
               status = ST_BAD_CHANNEL;
            end else begin
               wr_open_in[ch] = 1'b0;
               if (!rd_open_ff[ch]) begin
                  in_use_in[ch] = 1'b0;
               end
            end
         end
         MODE_QUERY: begin
            if (!ch_ok) begin
               status = ST_BAD_CHANNEL;
            end
         end
         MODE_WRITE: begin
            if (!ch_ok || !in_use_ff[ch]) begin
               status = ST_BAD_CHANNEL;
            end else if (!rd_open_ff[ch]) begin
               status = ST_NO_READER;
            end else if (next_slot(cur_wr) == cur_rd) begin
               status = ST_WOULD_BLOCK;
            end else begin
               mem_req.we    = fire;
               mem_req.addr  = ADDR_W'(ch) * ADDR_W'(RING_BYTES) + ADDR_W'(cur_wr);
               mem_req.wdata = data_in;
               wr_idx_in[ch] = next_slot(cur_wr);
               moved         = 1'b1;
            end
         end
         MODE_READ: begin
            if (!ch_ok || !in_use_ff[ch]) begin
               status = ST_BAD_CHANNEL;
            end else if (cur_wr == cur_rd) begin
               status = wr_open_ff[ch] ? ST_WOULD_BLOCK : ST_END_OF_DATA;
            end else begin
               mem_req.re    = fire;
               mem_req.addr  = ADDR_W'(ch) * ADDR_W'(RING_BYTES) + ADDR_W'(cur_rd);
               rd_idx_in[ch] = next_slot(cur_rd);
               moved         = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // transfer count: saturating add, cleared once the transfer ends
   assign count_mid = (moved && count_ff != COUNT_MAX) ? count_ff + COUNT_W'(1) : count_ff;
   assign clear     = (mode == MODE_WRITE || mode == MODE_READ) &&
                      (last_byte || status == ST_BAD_CHANNEL ||
                       status == ST_NO_READER || status == ST_END_OF_DATA);
   assign count_in  = clear ? '0 : count_mid;

   // has_data looks at the table after this item
   assign out_ok  = {1'b0, ch_out} < (CHAN_W + 1)'(NUM_CHANNELS);
   assign out_idx = ch_out[CH_W-1:0];

   always_comb begin
      result.status      = status;
      result.channel_out = ch_out;
      result.has_data    = out_ok && in_use_in[out_idx] &&
                           (wr_idx_in[out_idx] != rd_idx_in[out_idx]);
      result.bytes_done  = count_mid;
      result.rd_pending  = mem_req.re;
   end

   // table state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff  <= '0;
         rd_open_ff <= '0;
         wr_open_ff <= '0;
         count_ff   <= '0;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            wr_idx_ff[i] <= '0;
            rd_idx_ff[i] <= '0;
         end
      end else if (fire) begin
         in_use_ff  <= in_use_in;
         rd_open_ff <= rd_open_in;
         wr_open_ff <= wr_open_in;
         count_ff   <= count_in;
         wr_idx_ff  <= wr_idx_in;
         rd_idx_ff  <= rd_idx_in;
      end
   end
endmodule

FILE: hdl/multi_channel_byte_pipe.sv
// Top level of the multi-channel byte pipe: input register, channel control,
// ring memory and result register. Depends on mbp_pkg, mbp_if, mbp_ram, mbp_ctrl.
//
// Usage
//   req_if carries one item per handshake: mode, channel, data_in, last_byte.
//   rsp_if returns exactly one item per request, in order: status, data_out,
//   channel_out, has_data, bytes_done.
//   The result passes through the input register, then the result register;
//   a read byte gets its data from the registered read port of the ring memory
//   as the item enters the result register.
//   Throughput: one item per cycle unless rsp_if.ready stalls; each item touches one
//   channel's table entry and at most one ring byte through the single memory port pair.
//   Reset: synchronous; all channels are free, indices and the transfer
//   count are zero. The ring memory is not cleared and needs no clearing
//   pass, since a byte is only read after it has been written.
//   Stall: when rsp_if.ready is low the result register holds, the input
//   register holds behind it, and req_if.ready drops once both are full.
//   Table state advances only as an item moves from the input register to
//   the result register, so a stall never changes a decision.
module multi_channel_byte_pipe (
   input  logic      clock,
   input  logic      reset,
   mbp_req_if.sink   req_if,
   mbp_rsp_if.source rsp_if
);
   import mbp_pkg::*;

   logic              a_valid_ff;
   logic [MODE_W-1:0] a_mode_ff;
   logic [CHAN_W-1:0] a_chan_ff;
   logic [BYTE_W-1:0] a_data_ff;
   logic              a_last_ff;
   logic              a_fire;

   logic               b_valid_ff;
   status_type         b_status_ff;
   logic [CHAN_W-1:0]  b_chan_ff;
   logic               b_has_ff;
   logic [COUNT_W-1:0] b_bytes_ff;
   logic               b_rd_ff;

   mem_req_type       mem_req;
   result_type        result;
   logic [BYTE_W-1:0] ram_rdata;

   // handshake: input register moves when the result register is free
   assign a_fire       = a_valid_ff && (!b_valid_ff || rsp_if.ready);
   assign req_if.ready = !a_valid_ff || a_fire;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         a_valid_ff <= req_if.valid;
      end
      if (req_if.valid && req_if.ready) begin
         a_mode_ff <= req_if.mode;
         a_chan_ff <= req_if.channel;
         a_data_ff <= req_if.data_in;
         a_last_ff <= req_if.last_byte;
      end
   end

   // channel table and decision
   mbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .fire      (a_fire),
      .mode      (a_mode_ff),
      .channel   (a_chan_ff),
      .data_in   (a_data_ff),
      .last_byte (a_last_ff),
      .mem_req   (mem_req),
      .result    (result)
   );

   // ring memory for all channels
   mbp_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_ring (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.addr),
      .wdata (mem_req.wdata),
      .re    (mem_req.re),
      .raddr (mem_req.addr),
      .rdata (ram_rdata)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         b_rd_ff    <= 1'b0;
      end else if (!b_valid_ff || rsp_if.ready) begin
         b_valid_ff <= a_fire;
         b_rd_ff    <= a_fire && result.rd_pending;
      end
      if (a_fire) begin
         b_status_ff <= result.status;
         b_chan_ff   <= result.channel_out;
         b_has_ff    <= result.has_data;
         b_bytes_ff  <= result.bytes_done;
      end
   end

   // response outputs
   assign rsp_if.valid       = b_valid_ff;
   assign rsp_if.status      = b_status_ff;
   assign rsp_if.data_out    = b_rd_ff ? ram_rdata : '0;
   assign rsp_if.channel_out = b_chan_ff;
   assign rsp_if.has_data    = b_has_ff;
   assign rsp_if.bytes_done  = b_bytes_ff;

   // memory read and write never come from the same item
   a_mem_one_op: assert property (@(posedge clock) disable iff (reset)
      !(mem_req.we && mem_req.re))
      else $error("ring write and read issued together");

   // a pending read byte always carries ok status
   a_rd_ok: assert property (@(posedge clock) disable iff (reset)
      b_rd_ff |-> (b_valid_ff && b_status_ff == ST_OK))
      else $error("read data pending on a failed item");

   // a read issued now lands in the result register next cycle
   a_rd_follow: assert property (@(posedge clock) disable iff (reset)
      mem_req.re |=> b_rd_ff)
      else $error("read issue lost before the result register");

   // has_data only on a channel in range
   a_has_range: assert property (@(posedge clock) disable iff (reset)
      (b_valid_ff && b_has_ff) |-> ({1'b0, b_chan_ff} < (CHAN_W + 1)'(NUM_CHANNELS)))
      else $error("has_data on a channel out of range");
endmodule

FILE: dv/multi_channel_byte_pipe_tb.sv
// Self-checking testbench for multi_channel_byte_pipe: drives request items with random
// idling, predicts every response in order and checks each field of each response item.
// Depends on mbp_pkg, mbp_if and the multi_channel_byte_pipe RTL.
module multi_channel_byte_pipe_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mbp_pkg::*;

   // modes outside the defined set, answered with ok and no change
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   localparam int QUIET_LIMIT = 2000;
   localparam int DRAIN_CYCLES = 6;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [CHAN_W-1:0] channel;
      logic [BYTE_W-1:0] data_in;
      logic              last_byte;
   } pipe_req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [BYTE_W-1:0]   data_out;
      logic [CHAN_W-1:0]   channel_out;
      logic                has_data;
      logic [COUNT_W-1:0]  bytes_done;
   } pipe_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mbp_req_if req_if();
   mbp_rsp_if rsp_if();

   multi_channel_byte_pipe dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // clock, 4 ns period
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // shadow pipe table
   logic               chan_used [NUM_CHANNELS];
   logic               rd_open   [NUM_CHANNELS];
   logic               wr_open   [NUM_CHANNELS];
   logic [IDX_W-1:0]   wr_ptr    [NUM_CHANNELS];
   logic [IDX_W-1:0]   rd_ptr    [NUM_CHANNELS];
   logic [BYTE_W-1:0]  ring_mem  [DEPTH];
   logic [COUNT_W-1:0] xfer_count;

   pipe_req_type pending_reqs[$];
   pipe_rsp_type expected_rsps[$];

   int req_accepted = 0;
   int rsp_accepted = 0;
   int err_count = 0;
   int quiet_cycles = 0;

   function automatic logic [IDX_W-1:0] ring_advance(input logic [IDX_W-1:0] idx);
      return IDX_W'((int'(idx) + 1) % RING_BYTES);
   endfunction

   // one request through the shadow table, returns the response it should give
   function automatic pipe_rsp_type step_pipe(input pipe_req_type rq);
      pipe_rsp_type rs;
      int           ch;
      int           ch_out;
      logic         in_range;
      ch = int'(rq.channel);
      ch_out = ch;
      in_range = (ch < NUM_CHANNELS);
      rs.status = ST_OK;
      rs.data_out = '0;
      case (rq.mode)
         MODE_CREATE: begin
            rs.status = ST_NO_FREE;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
               if (!chan_used[i] && rs.status == ST_NO_FREE) begin
                  chan_used[i] = 1'b1;
                  rd_open[i] = 1'b1;
                  wr_open[i] = 1'b1;
                  wr_ptr[i] = '0;
                  rd_ptr[i] = '0;
                  ch_out = i;
                  rs.status = ST_OK;
               end
            end
         end
         MODE_CLOSE_RD, MODE_CLOSE_WR, MODE_QUERY: begin
            if (!in_range) begin
               rs.status = ST_BAD_CHANNEL;
            end else if (rq.mode != MODE_QUERY) begin
               if (rq.mode == MODE_CLOSE_RD) begin
                  rd_open[ch] = 1'b0;
               end else begin
                  wr_open[ch] = 1'b0;
               end
               if (!rd_open[ch] && !wr_open[ch]) begin
                  chan_used[ch] = 1'b0;
               end
            end
         end
         MODE_WRITE, MODE_READ: begin
            if (!in_range) begin
               rs.status = ST_BAD_CHANNEL;
            end else if (!chan_used[ch]) begin
               rs.status = ST_BAD_CHANNEL;
            end else if (rq.mode == MODE_WRITE) begin
               if (!rd_open[ch]) begin
                  rs.status = ST_NO_READER;
               end else if (ring_advance(wr_ptr[ch]) == rd_ptr[ch]) begin
                  rs.status = ST_WOULD_BLOCK;
               end else begin
                  ring_mem[ch * RING_BYTES + int'(wr_ptr[ch])] = rq.data_in;
                  wr_ptr[ch] = ring_advance(wr_ptr[ch]);
                  if (xfer_count != COUNT_MAX) xfer_count = xfer_count + 1'b1;
               end
            end else begin
               if (wr_ptr[ch] == rd_ptr[ch]) begin
                  rs.status = wr_open[ch] ? ST_WOULD_BLOCK : ST_END_OF_DATA;
               end else begin
                  rs.data_out = ring_mem[ch * RING_BYTES + int'(rd_ptr[ch])];
                  rd_ptr[ch] = ring_advance(rd_ptr[ch]);
                  if (xfer_count != COUNT_MAX) xfer_count = xfer_count + 1'b1;
               end
            end
         end
         default: ;
      endcase
      rs.channel_out = CHAN_W'(ch_out);
      rs.has_data = 1'b0;
      if (ch_out < NUM_CHANNELS) begin
         rs.has_data = chan_used[ch_out] && (wr_ptr[ch_out] != rd_ptr[ch_out]);
      end
      rs.bytes_done = xfer_count;
      // transfer ends on last byte or on a status that stops it
      if ((rq.mode == MODE_WRITE || rq.mode == MODE_READ) &&
          (rq.last_byte || rs.status == ST_BAD_CHANNEL ||
           rs.status == ST_NO_READER || rs.status == ST_END_OF_DATA)) begin
         xfer_count = '0;
      end
      return rs;
   endfunction

   function automatic bit idle_pick(input int n);
      if (n >= 200 && n < 350) return 1'b0;
      return $urandom_range(0, 99) < 33;
   endfunction

   task automatic queue_req(input logic [MODE_W-1:0] mode, input int ch,
                            input int data, input bit last);
      pipe_req_type rq;
      rq.mode = mode;
      rq.channel = CHAN_W'(ch);
      rq.data_in = BYTE_W'(data);
      rq.last_byte = last;
      pending_reqs.push_back(rq);
   endtask

   task automatic check_field(input string name, input logic [COUNT_W-1:0] exp_val,
                              input logic [COUNT_W-1:0] got_val);
      if (got_val !== exp_val) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name,
                  exp_val, got_val);
         err_count++;
      end
   endtask

   // request driver and predictor
   always @(posedge clock) begin : req_driver
      pipe_req_type rq;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            rq.mode = req_if.mode;
            rq.channel = req_if.channel;
            rq.data_in = req_if.data_in;
            rq.last_byte = req_if.last_byte;
            expected_rsps.push_back(step_pipe(rq));
            req_accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_reqs.size() != 0 && !idle_pick(req_accepted)) begin
               rq = pending_reqs.pop_front();
               req_if.mode <= rq.mode;
               req_if.channel <= rq.channel;
               req_if.data_in <= rq.data_in;
               req_if.last_byte <= rq.last_byte;
               req_if.valid <= 1'b1;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin : rsp_monitor
      pipe_rsp_type exp_rsp;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= !idle_pick(rsp_accepted);
         if (rsp_if.valid && rsp_if.ready) begin
            rsp_accepted++;
            if (expected_rsps.size() == 0) begin
               $display("%0t: unexpected response item, status %0d channel_out %0d",
                        $realtime, rsp_if.status, rsp_if.channel_out);
               err_count++;
            end else begin
               exp_rsp = expected_rsps.pop_front();
               check_field("status", COUNT_W'(exp_rsp.status), COUNT_W'(rsp_if.status));
               check_field("data_out", COUNT_W'(exp_rsp.data_out),
                           COUNT_W'(rsp_if.data_out));
               check_field("channel_out", COUNT_W'(exp_rsp.channel_out),
                           COUNT_W'(rsp_if.channel_out));
               check_field("has_data", COUNT_W'(exp_rsp.has_data),
                           COUNT_W'(rsp_if.has_data));
               check_field("bytes_done", exp_rsp.bytes_done, rsp_if.bytes_done);
            end
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("multi_channel_byte_pipe verification failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // stimulus, reset and end of run
   initial begin
      int varied;
      int kind;
      int ch;
      int len;

      req_if.valid = 1'b0;
      req_if.mode = '0;
      req_if.channel = '0;
      req_if.data_in = '0;
      req_if.last_byte = 1'b0;
      rsp_if.ready = 1'b0;
      xfer_count = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         chan_used[i] = 1'b0;
         rd_open[i] = 1'b0;
         wr_open[i] = 1'b0;
         wr_ptr[i] = '0;
         rd_ptr[i] = '0;
      end

      // directed: unused channel, create, round trip, bad channels, spare modes
      queue_req(MODE_QUERY, 0, 0, 1'b0);
      queue_req(MODE_WRITE, 0, 8'h5a, 1'b0);
      queue_req(MODE_READ, 0, 0, 1'b0);
      queue_req(MODE_CLOSE_RD, 3, 0, 1'b0);
      queue_req(MODE_CREATE, 9, 8'hff, 1'b1);
      queue_req(MODE_WRITE, 0, 8'h00, 1'b0);
      queue_req(MODE_WRITE, 0, 8'hff, 1'b1);
      queue_req(MODE_QUERY, 0, 0, 1'b0);
      queue_req(MODE_READ, 0, 0, 1'b0);
      queue_req(MODE_READ, 0, 0, 1'b1);
      queue_req(MODE_READ, 0, 0, 1'b0);
      queue_req(MODE_WRITE, 15, 8'hff, 1'b1);
      queue_req(MODE_CLOSE_WR, 8, 0, 1'b0);
      queue_req(MODE_QUERY, 8, 0, 1'b0);
      queue_req(MODE_SPARE_LO, 15, 8'hff, 1'b1);
      queue_req(MODE_SPARE_HI, 0, 0, 1'b0);
      // reader gone, then writer gone frees the channel
      queue_req(MODE_CLOSE_RD, 0, 0, 1'b0);
      queue_req(MODE_WRITE, 0, 8'h11, 1'b0);
      queue_req(MODE_CLOSE_WR, 0, 0, 1'b0);
      // data left behind a closed writer, then end of data
      queue_req(MODE_CREATE, 0, 0, 1'b0);
      queue_req(MODE_WRITE, 0, 8'ha5, 1'b0);
      queue_req(MODE_CLOSE_WR, 0, 0, 1'b0);
      queue_req(MODE_READ, 0, 0, 1'b0);
      queue_req(MODE_READ, 0, 0, 1'b0);
      queue_req(MODE_CLOSE_RD, 0, 0, 1'b0);

      // claim every channel and one more, then fill one ring past full
      for (int i = 0; i <= NUM_CHANNELS; i++) queue_req(MODE_CREATE, i, 0, 1'b0);
      for (int i = 0; i < RING_BYTES; i++) begin
         queue_req(MODE_WRITE, 2, $urandom_range(0, 255), $urandom_range(0, 31) == 0);
      end

      // random traffic, mostly well-formed bursts on low channels
      varied = 0;
      while (varied < 160) begin
         kind = $urandom_range(0, 99);
         ch = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 7);
         len = $urandom_range(1, 8);
         if (kind < 10) begin
            queue_req(MODE_CREATE, $urandom_range(0, 15), $urandom_range(0, 255),
                      $urandom_range(0, 1));
            varied++;
         end else if (kind < 42) begin
            for (int i = 0; i < len; i++) begin
               queue_req(MODE_WRITE, ch, $urandom_range(0, 255), i == len - 1);
            end
            varied += len;
         end else if (kind < 74) begin
            for (int i = 0; i < len; i++) queue_req(MODE_READ, ch, 0, i == len - 1);
            varied += len;
         end else if (kind < 82) begin
            queue_req(($urandom_range(0, 1) != 0) ? MODE_CLOSE_RD : MODE_CLOSE_WR,
                      ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : ch,
                      $urandom_range(0, 255), $urandom_range(0, 1));
            varied++;
         end else if (kind < 90) begin
            queue_req(MODE_QUERY, $urandom_range(0, 15), $urandom_range(0, 255),
                      $urandom_range(0, 1));
            varied++;
         end else begin
            queue_req(MODE_W'($urandom_range(0, 7)), $urandom_range(0, 15),
                      $urandom_range(0, 255), $urandom_range(0, 1));
            varied++;
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // drain, then give the pipeline time to show stray responses
      while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (err_count == 0) begin
         $display("multi_channel_byte_pipe verification clean");
      end else begin
         $display("multi_channel_byte_pipe verification failed");
      end
      $finish;
   end

endmodule
